// ----- src/k_nearest_sorted_insert_core_assert.svh -----
// Assertion macros shared by the checker modules of this block.
`ifndef K_NEAREST_SORTED_INSERT_CORE_ASSERT_SVH
`define K_NEAREST_SORTED_INSERT_CORE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define KNN_ASSERT_IMPLIES(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// The condition must hold in the cycle after the trigger.
`define KNN_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- src/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// Widths, constants and the structures passed between the distance front
// end, the list cells and the top level of the k-nearest insert core.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int ID_W    = 16;
    localparam int COORD_W = 16;
    localparam int TERM_W  = 2 * COORD_W;
    localparam int DIST_W  = 38;
    localparam int SLOT_W  = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Input item kinds.
    localparam logic KIND_COORD = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Item leaving the accumulate stage.
    typedef struct packed {
        logic              valid;
        logic              clear;
        logic              last;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } dist_out_t;

    // Commands broadcast to every list cell.
    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctrl_t;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic              hit;
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } link_t;

endpackage

// ----- src/k_nearest_sorted_insert_core.sv -----
// ----------------------------------------------------------------------------
// k_nearest_sorted_insert_core
// The last coordinate's result reaches the port through the squaring, accumulate and output registers.
// Throughput: one item per cycle; input stalls only while a result waits unread.
// Reset (synchronous, active low) empties the list and zeroes the distance sum.
// ----------------------------------------------------------------------------
module k_nearest_sorted_insert_core import knn_pkg::*; #(
    parameter int LIST_SIZE = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [ID_W-1:0]           s_candidate_id,
    input  logic signed [COORD_W-1:0] s_candidate_coord,
    input  logic signed [COORD_W-1:0] s_query_coord,
    input  logic                      s_last_coordinate,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_inserted,
    output logic [SLOT_W-1:0]         m_slot,
    output logic [DIST_W-1:0]         m_squared_distance
);

    dist_out_t         stage;
    cell_ctrl_t        ctrl;
    logic              advance;
    logic              emits;
    link_t             links [LIST_SIZE+1];
    logic [LIST_SIZE-1:0] ins;
    logic [SLOT_W-1:0] slot_codes [LIST_SIZE];
    logic [SLOT_W-1:0] slot_any;

    logic              out_valid_reg, out_valid_next;
    logic              out_ins_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [DIST_W-1:0] out_dist_reg;

    // The pipe only halts when a result must be written and the output
    // register still holds one that has not been taken.
    assign emits   = stage.valid && !stage.clear && stage.last;
    assign advance = !(emits && out_valid_reg && !m_ready);
    assign s_ready = advance;

    assign ctrl.load  = advance && emits;
    assign ctrl.clear = advance && stage.valid && stage.clear;

    knn_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .in_kind   (s_kind),
        .in_id     (s_candidate_id),
        .in_cand   (s_candidate_coord),
        .in_query  (s_query_coord),
        .in_last   (s_last_coordinate),
        .stage_out (stage)
    );

    assign links[0] = '0;

    for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
        knn_cell #(.IDX(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .new_id    (stage.id),
            .new_dist  (stage.distance),
            .prev      (links[i]),
            .link      (links[i+1]),
            .ins       (ins[i]),
            .slot_code (slot_codes[i])
        );
    end

    always_comb begin
        slot_any = '0;
        for (int i = 0; i < LIST_SIZE; i++) begin
            slot_any = slot_any | slot_codes[i];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            out_ins_reg  <= |ins;
            out_slot_reg <= slot_any;
            out_dist_reg <= stage.distance;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_inserted         = out_ins_reg;
    assign m_slot             = out_slot_reg;
    assign m_squared_distance = out_dist_reg;

endmodule

// ----- src/knn_dist.sv -----
// ----------------------------------------------------------------------------
// knn_dist
// Squared-distance front end: one stage squares the coordinate difference,
// the next adds it into the saturating per-candidate accumulator.
// ----------------------------------------------------------------------------
module knn_dist import knn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic                      in_kind,
    input  logic [ID_W-1:0]           in_id,
    input  logic signed [COORD_W-1:0] in_cand,
    input  logic signed [COORD_W-1:0] in_query,
    input  logic                      in_last,
    output dist_out_t                 stage_out
);

    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] diff_neg;
    logic [COORD_W-1:0]      mag;
    logic [TERM_W-1:0]       term;

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_kind_reg;
    logic                    s1_last_reg;
    logic [ID_W-1:0]         s1_id_reg;
    logic [TERM_W-1:0]       s1_term_reg;

    logic [DIST_W:0]         sum;
    logic [DIST_W-1:0]       sat;
    logic [DIST_W-1:0]       acc_reg, acc_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    s2_clear_reg;
    logic                    s2_last_reg;
    logic [ID_W-1:0]         s2_id_reg;
    logic [DIST_W-1:0]       s2_dist_reg;

    // The difference of two 16-bit values needs 17 bits; its magnitude fits 16.
    assign diff     = {in_cand[COORD_W-1], in_cand} - {in_query[COORD_W-1], in_query};
    assign diff_neg = -diff;
    assign mag      = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
    assign term     = mag * mag;

    assign sum = {1'b0, acc_reg} + {{(DIST_W-TERM_W+1){1'b0}}, s1_term_reg};
    assign sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    always_comb begin
        s1_valid_next = advance ? in_valid : s1_valid_reg;
        s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;
        acc_next      = acc_reg;
        if (advance && s1_valid_reg) begin
            if (s1_kind_reg == KIND_CLEAR || s1_last_reg) begin
                acc_next = '0;
            end else begin
                acc_next = sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_kind_reg  <= in_kind;
            s1_last_reg  <= in_last;
            s1_id_reg    <= in_id;
            s1_term_reg  <= term;
            s2_clear_reg <= (s1_kind_reg == KIND_CLEAR);
            s2_last_reg  <= s1_last_reg;
            s2_id_reg    <= s1_id_reg;
            s2_dist_reg  <= sat;
        end
    end

    assign stage_out.valid    = s2_valid_reg;
    assign stage_out.clear    = s2_clear_reg;
    assign stage_out.last     = s2_last_reg;
    assign stage_out.id       = s2_id_reg;
    assign stage_out.distance = s2_dist_reg;

endmodule

// ----- src/knn_cell.sv -----
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted neighbor list. It compares the new distance with
// its own entry and either keeps it, takes the new candidate, or takes the
// entry of its left neighbor when the insert point lies further left; a clear empties it.
// ----------------------------------------------------------------------------
module knn_cell import knn_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [ID_W-1:0]   new_id,
    input  logic [DIST_W-1:0] new_dist,
    input  link_t             prev,
    output link_t             link,
    output logic              ins,
    output logic [SLOT_W-1:0] slot_code
);

    localparam logic [SLOT_W-1:0] SLOT_VAL = SLOT_W'(IDX);

    logic              valid_reg, valid_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              hit;

    // Empty slots count as infinitely far; the list stays sorted, so hits
    // form a contiguous run to the right end of the row.
    assign hit       = !valid_reg || (new_dist <= dist_reg);
    assign ins       = hit && !prev.hit;
    assign slot_code = ins ? SLOT_VAL : '0;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        dist_next  = dist_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.load) begin
            if (prev.hit) begin
                valid_next = prev.valid;
                id_next    = prev.id;
                dist_next  = prev.distance;
            end else if (hit) begin
                valid_next = 1'b1;
                id_next    = new_id;
                dist_next  = new_dist;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        dist_reg <= dist_next;
    end

    assign link.hit      = hit;
    assign link.valid    = valid_reg;
    assign link.id       = id_reg;
    assign link.distance = dist_reg;

endmodule

// ----- src/knn_checker.sv -----
// ----------------------------------------------------------------------------
// knn_checker
// Port-level checks for the k-nearest insert core, bound to the top level.
// ----------------------------------------------------------------------------
`include "k_nearest_sorted_insert_core_assert.svh"

module knn_checker import knn_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_inserted,
    input logic [SLOT_W-1:0] m_slot,
    input logic [DIST_W-1:0] m_squared_distance
);

    logic [DIST_W+SLOT_W:0] m_payload;
    logic                   zero_distance;

    assign m_payload     = {m_inserted, m_slot, m_squared_distance};
    assign zero_distance = (m_squared_distance == '0);

    // A result that is not taken stays on the port unchanged.
    `KNN_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // A candidate that was turned away reports slot code zero.
    `KNN_ASSERT_IMPLIES(a_reject_slot, aclk, aresetn, m_valid && !m_inserted, m_slot == '0)

    // A zero distance is never farther than any entry, so it lands in front.
    `KNN_ASSERT_IMPLIES(a_zero_front, aclk, aresetn, m_valid && zero_distance, m_inserted && m_slot == '0)

    // With the output register empty nothing can hold the input side back.
    `KNN_ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

endmodule

bind k_nearest_sorted_insert_core knn_checker u_knn_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_inserted         (m_inserted),
    .m_slot             (m_slot),
    .m_squared_distance (m_squared_distance)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k-nearest sorted insert core testbench
// Streams coordinate pairs and clear items into the core and predicts each
// result with its own copy of the sorted neighbor list and distance sum.
// Results are checked field by field, in order, under random stalls on both
// channels, one long receiver hold-off and two full drains of the core.
// ----------------------------------------------------------------------------
module testbench;
    import knn_pkg::*;

    localparam int NUM_SLOTS     = 8;
    localparam int ITEM_TARGET   = 950;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RX_CALM_FROM  = 100;
    localparam int RX_CALM_TO    = 180;
    localparam int TX_CALM_FROM  = 300;
    localparam int TX_CALM_TO    = 500;

    typedef enum int {
        STYLE_WIDE,
        STYLE_NEAR,
        STYLE_EXTREME
    } coord_style_t;

    typedef struct {
        logic                      kind;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] cand;
        logic signed [COORD_W-1:0] query;
        logic                      last;
        bit                        wait_drain;
    } coord_item_t;

    typedef struct {
        logic              inserted;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] distance;
    } neighbor_result_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_kind = KIND_COORD;
    logic [ID_W-1:0]           s_candidate_id = '0;
    logic signed [COORD_W-1:0] s_candidate_coord = '0;
    logic signed [COORD_W-1:0] s_query_coord = '0;
    logic                      s_last_coordinate = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_inserted;
    logic [SLOT_W-1:0]         m_slot;
    logic [DIST_W-1:0]         m_squared_distance;

    coord_item_t      pending_items[$];
    neighbor_result_t expected_results[$];
    coord_item_t      next_item;
    neighbor_result_t want;
    bit               drain_next = 1'b0;

    // Predicted neighbor list and running distance sum.
    logic [ID_W-1:0] list_id[NUM_SLOTS];
    longint          list_dist[NUM_SLOTS];
    bit              list_valid[NUM_SLOTS];
    longint          dist_sum = 0;

    int error_count    = 0;
    int results_seen   = 0;
    int accepted_count = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    k_nearest_sorted_insert_core #(
        .LIST_SIZE(NUM_SLOTS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_candidate_id    (s_candidate_id),
        .s_candidate_coord (s_candidate_coord),
        .s_query_coord     (s_query_coord),
        .s_last_coordinate (s_last_coordinate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_inserted        (m_inserted),
        .m_slot            (m_slot),
        .m_squared_distance(m_squared_distance)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Updates the predicted list for one accepted item and queues the
    // expected result when the item closes a candidate.
    function automatic void update_neighbor_list(input logic kind,
                                                 input logic [ID_W-1:0] id,
                                                 input logic signed [COORD_W-1:0] cand,
                                                 input logic signed [COORD_W-1:0] query,
                                                 input logic last);
        longint           diff;
        longint           sum;
        int               pos;
        bit               found;
        neighbor_result_t r;
        if (kind == KIND_CLEAR) begin
            for (int i = 0; i < NUM_SLOTS; i++) list_valid[i] = 1'b0;
            dist_sum = 0;
            return;
        end
        diff = longint'(cand) - longint'(query);
        sum  = dist_sum + diff * diff;
        if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
        dist_sum = sum;
        if (!last) return;
        dist_sum = 0;
        found = 1'b0;
        pos   = 0;
        // Empty slots are infinitely far; ties go ahead of the old entry.
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && (!list_valid[i] || sum <= list_dist[i])) begin
                pos   = i;
                found = 1'b1;
            end
        end
        if (found) begin
            for (int i = NUM_SLOTS - 1; i > pos; i--) begin
                list_id[i]    = list_id[i-1];
                list_dist[i]  = list_dist[i-1];
                list_valid[i] = list_valid[i-1];
            end
            list_id[pos]    = id;
            list_dist[pos]  = sum;
            list_valid[pos] = 1'b1;
        end
        r.inserted = found;
        r.slot     = found ? pos[SLOT_W-1:0] : '0;
        r.distance = sum[DIST_W-1:0];
        expected_results.push_back(r);
    endfunction

    task automatic add_item(input logic kind, input logic [ID_W-1:0] id,
                            input logic signed [COORD_W-1:0] cand,
                            input logic signed [COORD_W-1:0] query, input logic last);
        coord_item_t it;
        it.kind       = kind;
        it.id         = id;
        it.cand       = cand;
        it.query      = query;
        it.last       = last;
        it.wait_drain = drain_next;
        drain_next    = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_candidate(input int dims, input coord_style_t style);
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] q;
        id = $urandom;
        for (int d = 0; d < dims; d++) begin
            case (style)
                STYLE_WIDE: begin
                    c = $urandom;
                    q = $urandom;
                end
                STYLE_NEAR: begin
                    // Small offsets make equal distances common.
                    q = $urandom;
                    c = q + 16'($urandom_range(0, 6)) - 16'd3;
                end
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        c = 16'sh8000;
                        q = 16'sh7FFF;
                    end else begin
                        c = 16'sh7FFF;
                        q = 16'sh8000;
                    end
                end
            endcase
            add_item(KIND_COORD, id, c, q, d == dims - 1);
        end
    endtask

    // Driver: predicts on each transfer, then offers the next item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_neighbor_list(s_kind, s_candidate_id, s_candidate_coord,
                                     s_query_coord, s_last_coordinate);
                accepted_count <= accepted_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0
                    && !(pending_items[0].wait_drain && expected_results.size() != 0)
                    && ((accepted_count >= TX_CALM_FROM && accepted_count < TX_CALM_TO)
                        || $urandom_range(0, 99) >= 8)) begin
                    next_item = pending_items.pop_front();
                    s_valid           <= 1'b1;
                    s_kind            <= next_item.kind;
                    s_candidate_id    <= next_item.id;
                    s_candidate_coord <= next_item.cand;
                    s_query_coord     <= next_item.query;
                    s_last_coordinate <= next_item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness, with one long hold-off so the core backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= (results_seen >= RX_CALM_FROM && results_seen < RX_CALM_TO)
                       || $urandom_range(0, 99) >= 8;
        end
    end

    // Monitor: every result transfer is matched with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result inserted=%0b slot=%0d distance=%0d",
                         $time, m_inserted, m_slot, m_squared_distance);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_inserted !== want.inserted) begin
                    $display("%0t: inserted expected %0b actual %0b",
                             $time, want.inserted, m_inserted);
                    error_count++;
                end
                if (m_slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, m_slot);
                    error_count++;
                end
                if (m_squared_distance !== want.distance) begin
                    $display("%0t: squared_distance expected %0d actual %0d",
                             $time, want.distance, m_squared_distance);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int pick;
        bit mid_drain_set;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            list_id[i]    = '0;
            list_dist[i]  = 0;
            list_valid[i] = 1'b0;
        end
        mid_drain_set = 1'b0;

        // Clear with every other field set, then a fresh list.
        add_item(KIND_CLEAR, 16'hFFFF, -16'sd1, -16'sd1, 1'b1);
        add_item(KIND_COORD, 16'h0000, 16'sd0, 16'sd0, 1'b1);
        add_item(KIND_COORD, 16'hFFFF, 16'sh8000, 16'sh7FFF, 1'b1);
        // Same distance as the previous one: goes in ahead of it.
        add_item(KIND_COORD, 16'h0002, 16'sh7FFF, 16'sh8000, 1'b1);
        add_item(KIND_COORD, 16'h0003, 16'sd100, -16'sd100, 1'b0);
        add_item(KIND_COORD, 16'h0003, 16'sd5, 16'sd5, 1'b1);
        add_item(KIND_COORD, 16'h0004, 16'sd256, 16'sd0, 1'b1);
        add_item(KIND_COORD, 16'h0005, -16'sd1, 16'sd1, 1'b1);
        add_item(KIND_COORD, 16'h0006, 16'sd0, 16'sd3, 1'b1);
        add_item(KIND_COORD, 16'h0007, 16'sd7, 16'sd0, 1'b1);
        // List is full; a farther candidate is not inserted.
        add_item(KIND_COORD, 16'h0008, 16'sh8000, 16'sh7FFF, 1'b0);
        add_item(KIND_COORD, 16'h0008, 16'sh7FFF, 16'sh8000, 1'b1);
        add_item(KIND_COORD, 16'h0009, 16'sd0, 16'sd0, 1'b1);
        add_item(KIND_COORD, 16'h000A, 16'sh8000, 16'sh7FFF, 1'b1);
        add_item(KIND_CLEAR, 16'h0000, 16'sd0, 16'sd0, 1'b0);
        add_item(KIND_COORD, 16'h000B, 16'sd1234, -16'sd4321, 1'b1);
        // A clear in the middle of a candidate drops the partial sum.
        add_item(KIND_COORD, 16'h000C, 16'sh7FFF, 16'sd0, 1'b0);
        add_item(KIND_CLEAR, 16'h5A5A, 16'sh1234, 16'sh4321, 1'b1);
        add_item(KIND_COORD, 16'h000D, 16'sd1, 16'sd0, 1'b1);

        drain_next = 1'b1;
        add_candidate($urandom_range(65, 72), STYLE_EXTREME);

        while (pending_items.size() < ITEM_TARGET) begin
            if (!mid_drain_set && pending_items.size() >= ITEM_TARGET / 2) begin
                drain_next    = 1'b1;
                mid_drain_set = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                add_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
            end else if (pick < 8) begin
                // Noise: any kind, any last flag.
                add_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
            end else if (pick == 8) begin
                add_candidate($urandom_range(60, 72), STYLE_EXTREME);
            end else if (pick < 54) begin
                add_candidate($urandom_range(1, 4), STYLE_NEAR);
            end else begin
                add_candidate($urandom_range(1, 4), STYLE_WIDE);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
